>>> src/g2d_pkg.sv
// Package for the packet deframer: byte roles, parser phases, control byte masks
// and the record type that moves through the queue. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package g2d_pkg;

  // Fields of the control byte.
  localparam logic [7:0] MASK_LENLEN   = 8'hC0;
  localparam logic [7:0] MASK_TYPELEN  = 8'h38;
  localparam logic [7:0] MASK_FLAGS    = 8'h07;
  localparam logic [7:0] FLAG_COMPOUND = 8'h04;
  localparam logic [7:0] FLAG_BIGEND   = 8'h02;

  localparam int unsigned LEN_W  = 24;
  localparam int unsigned TLEN_W = 4;

  typedef enum logic [2:0] {
    ROLE_TERM    = 3'd0,
    ROLE_CTRL    = 3'd1,
    ROLE_LEN     = 3'd2,
    ROLE_TYPE    = 3'd3,
    ROLE_PAYLOAD = 3'd4,
    ROLE_ERROR   = 3'd5
  } role_t;

  typedef enum logic [3:0] {
    PH_CTRL = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_TYPE = 4'b0100,
    PH_PAY  = 4'b1000
  } phase_t;

  // One classified byte, as the front end hands it to the back end.
  typedef struct packed {
    logic [7:0]        data_byte;
    role_t             role;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  plen;
    logic [TLEN_W-1:0] tlen;
    logic              compound;
    logic              err;
  } rec_t;

  // Front end to queue.
  typedef struct packed {
    logic push;
    rec_t rec;
  } push_t;

  // Queue status.
  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

endpackage

`default_nettype wire

>>> src/g2d_if.sv
// Channel interfaces of the packet deframer: the raw byte input and the tagged
// byte output. Each carries valid, ready and payload. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface g2d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface g2d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_echo;
  logic [2:0]  byte_role;
  logic        packet_first;
  logic        packet_last;
  logic [23:0] payload_length;
  logic [3:0]  type_length;
  logic        compound_flag;
  logic        error_flag;

  modport source (output valid, output byte_echo, output byte_role, output packet_first,
                  output packet_last, output payload_length, output type_length,
                  output compound_flag, output error_flag, input ready);
  modport sink (input valid, input byte_echo, input byte_role, input packet_first,
                input packet_last, input payload_length, input type_length,
                input compound_flag, input error_flag, output ready);
endinterface

`default_nettype wire

>>> src/g2d_front.sv
// Front end of the packet deframer: accepts bytes, tracks the framing state and
// classifies each byte into a record. Depends on g2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module g2d_front
  import g2d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_restart,
  input  wire qstat_t     q_stat,
  output push_t           q_push
);

  phase_t            phase_r, phase_nxt;
  logic [1:0]        lbl_r, lbl_nxt;     // length bytes left
  logic [1:0]        lidx_r, lidx_nxt;   // length byte index
  logic [LEN_W-1:0]  acc_r, acc_nxt;
  logic [TLEN_W-1:0] tbl_r, tbl_nxt;     // type bytes left
  logic [TLEN_W-1:0] tsize_r, tsize_nxt;
  logic [LEN_W-1:0]  pleft_r, pleft_nxt;
  logic              comp_r, comp_nxt;
  logic              err_r, err_nxt;

  role_t role;
  logic  first, last, fixed;
  logic  accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    lbl_nxt   = lbl_r;
    lidx_nxt  = lidx_r;
    acc_nxt   = acc_r;
    tbl_nxt   = tbl_r;
    tsize_nxt = tsize_r;
    pleft_nxt = pleft_r;
    comp_nxt  = comp_r;
    err_nxt   = err_r;
    role      = ROLE_ERROR;
    first     = 1'b0;
    last      = 1'b0;
    fixed     = 1'b1;

    // Restart drops the partial packet and the held error before classifying.
    if (in_restart) begin
      phase_nxt = PH_CTRL;
      lbl_nxt   = '0;
      lidx_nxt  = '0;
      acc_nxt   = '0;
      tbl_nxt   = '0;
      tsize_nxt = TLEN_W'(1);
      pleft_nxt = '0;
      comp_nxt  = 1'b0;
      err_nxt   = 1'b0;
    end

    if (err_nxt) begin
      role = ROLE_ERROR;
    end else begin
      unique case (phase_nxt)
        PH_CTRL: begin
          if (in_data_byte == 8'h00) begin
            role = ROLE_TERM;
          end else if ((in_data_byte & FLAG_BIGEND) != 8'h00) begin
            // Big-endian packets are not supported; hold the error.
            err_nxt   = 1'b1;
            phase_nxt = PH_CTRL;
            lbl_nxt   = '0;
            lidx_nxt  = '0;
            acc_nxt   = '0;
            tbl_nxt   = '0;
            tsize_nxt = TLEN_W'(1);
            pleft_nxt = '0;
            comp_nxt  = 1'b0;
            role      = ROLE_ERROR;
          end else begin
            lbl_nxt   = 2'((in_data_byte & MASK_LENLEN) >> 6);
            lidx_nxt  = '0;
            acc_nxt   = '0;
            tsize_nxt = TLEN_W'((in_data_byte & MASK_TYPELEN) >> 3) + TLEN_W'(1);
            tbl_nxt   = tsize_nxt;
            comp_nxt  = ((in_data_byte & MASK_FLAGS & FLAG_COMPOUND) != 8'h00);
            pleft_nxt = '0;
            phase_nxt = (lbl_nxt != 2'd0) ? PH_LEN : PH_TYPE;
            role      = ROLE_CTRL;
            first     = 1'b1;
            fixed     = 1'b0;
          end
        end
        PH_LEN: begin
          // Little-endian length field, one byte lane per index.
          unique case (lidx_nxt)
            2'd0:    acc_nxt = acc_nxt | {16'h0000, in_data_byte};
            2'd1:    acc_nxt = acc_nxt | {8'h00, in_data_byte, 8'h00};
            2'd2:    acc_nxt = acc_nxt | {in_data_byte, 16'h0000};
            default: acc_nxt = acc_nxt;
          endcase
          lidx_nxt = lidx_nxt + 2'd1;
          lbl_nxt  = lbl_nxt - 2'd1;
          if (lbl_nxt == 2'd0) begin
            phase_nxt = PH_TYPE;
          end
          role  = ROLE_LEN;
          fixed = 1'b0;
        end
        PH_TYPE: begin
          tbl_nxt = tbl_nxt - TLEN_W'(1);
          if (tbl_nxt == '0) begin
            pleft_nxt = acc_nxt;
            if (acc_nxt == '0) begin
              last      = 1'b1;
              phase_nxt = PH_CTRL;
            end else begin
              phase_nxt = PH_PAY;
            end
          end
          role  = ROLE_TYPE;
          fixed = 1'b0;
        end
        PH_PAY: begin
          pleft_nxt = pleft_nxt - LEN_W'(1);
          if (pleft_nxt == '0) begin
            last      = 1'b1;
            phase_nxt = PH_CTRL;
          end
          role  = ROLE_PAYLOAD;
          fixed = 1'b0;
        end
        default: begin
          phase_nxt = PH_CTRL;
          role      = ROLE_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    q_push.push              = accept;
    q_push.rec.data_byte     = in_data_byte;
    q_push.rec.role          = role;
    q_push.rec.first         = first;
    q_push.rec.last          = last;
    q_push.rec.plen          = fixed ? '0 : acc_nxt;
    q_push.rec.tlen          = fixed ? TLEN_W'(1) : tsize_nxt;
    q_push.rec.compound      = fixed ? 1'b0 : comp_nxt;
    q_push.rec.err           = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CTRL;
      lbl_r   <= '0;
      lidx_r  <= '0;
      acc_r   <= '0;
      tbl_r   <= '0;
      tsize_r <= TLEN_W'(1);
      pleft_r <= '0;
      comp_r  <= 1'b0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      lbl_r   <= lbl_nxt;
      lidx_r  <= lidx_nxt;
      acc_r   <= acc_nxt;
      tbl_r   <= tbl_nxt;
      tsize_r <= tsize_nxt;
      pleft_r <= pleft_nxt;
      comp_r  <= comp_nxt;
      err_r   <= err_nxt;
    end
  end

  // A packet can only open on a control byte.
  a_first_is_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push && q_push.rec.first |-> q_push.rec.role == ROLE_CTRL)
    else $error("packet opened on a non-control byte");

  // Once the error is held, only a restart clears it.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(err_r) && !$past(accept && in_restart) |-> err_r)
    else $error("held error cleared without restart");

  // The type counter is never zero while type bytes are expected.
  a_type_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TYPE |-> tbl_r != '0)
    else $error("type phase with no type bytes left");

endmodule

`default_nettype wire

>>> src/g2d_queue.sv
// Two-entry queue between the front and back ends of the packet deframer.
// Depends on g2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module g2d_queue
  import g2d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t q_push,
  input  wire logic  pop,
  output qstat_t     q_stat,
  output rec_t       head
);

  rec_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_stat.full      = (cnt_r == 2'd2);
  assign q_stat.not_empty = (cnt_r != 2'd0);
  assign head             = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push.push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !q_push.push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (q_push.push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      ent_r[wp_r] <= q_push.rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("pop from empty queue");

  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) == (wp_r != rp_r))
    else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

>>> src/g2d_back.sv
// Back end of the packet deframer: pulls classified records from the queue into
// the output register and drives the result channel. Depends on g2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module g2d_back
  import g2d_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qstat_t q_stat,
  input  wire rec_t   head,
  output logic        pop,
  g2d_out_if.source   out_ch
);

  logic ovalid_r;
  rec_t orec_r;

  // Refill the output register when it is empty or being drained.
  assign pop = q_stat.not_empty && (!ovalid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (pop) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      orec_r <= head;
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.byte_echo      = orec_r.data_byte;
  assign out_ch.byte_role      = orec_r.role;
  assign out_ch.packet_first   = orec_r.first;
  assign out_ch.packet_last    = orec_r.last;
  assign out_ch.payload_length = orec_r.plen;
  assign out_ch.type_length    = orec_r.tlen;
  assign out_ch.compound_flag  = orec_r.compound;
  assign out_ch.error_flag     = orec_r.err;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.ready |=> ovalid_r && $stable(orec_r))
    else $error("output changed while stalled");

  a_error_role: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && orec_r.err |-> orec_r.role == ROLE_ERROR)
    else $error("error held but role is not error");

  a_first_last_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && orec_r.first |-> !orec_r.last)
    else $error("control byte marked as last");

endmodule

`default_nettype wire

>>> src/g2_packet_deframer_core.sv
// Top level of the packet deframer: front end, two-entry queue and back end.
// Depends on g2d_pkg, g2d_if, g2d_front, g2d_queue and g2d_back.
//
//   Channel  Direction  Handshake      Carries
//   in_ch    input      valid/ready    data_byte, restart
//   out_ch   output     valid/ready    byte_echo, byte_role, packet_first, packet_last,
//                                      payload_length, type_length, compound_flag,
//                                      error_flag
//
// One byte is accepted per clock while in_ch.ready is high; each yields exactly one
// tagged transaction. The front end classifies a byte in the cycle it is accepted, so
// its framing state is ready for the next byte at once. The record then reaches out_ch
// through the two-entry queue and the output register, which absorb stalls: in_ch.ready
// drops only when out_ch has been stalled long enough to fill the queue.
// Reset (rst_n low, synchronous) returns the parser to expecting a control byte,
// clears the held error and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module g2_packet_deframer_core
  import g2d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  g2d_in_if.sink    in_ch,
  g2d_out_if.source out_ch
);

  push_t  q_push;
  qstat_t q_stat;
  rec_t   head;
  logic   pop;

  // Front end: tracks control, length, type and payload phases.
  g2d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .in_restart   (in_ch.restart),
    .q_stat       (q_stat),
    .q_push       (q_push)
  );

  // Queue decouples classification from delivery.
  g2d_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  // Back end: output register feeding out_ch.
  g2d_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
